@@ design/dkfx_pkg.sv @@
package dkfx_pkg;

    localparam int KIND_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int KEY_IDX_W = 6;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int TUSER_W   = KIND_W + 1;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = BYTE_W;

    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_KEY_A = 2'd1;
    localparam logic [KIND_W-1:0] KIND_KEY_B = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_A_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_B_LEN = 1'b1;

    localparam logic [CFG_W-1:0] LEN_RESET = 7'd1;

    typedef logic [BYTE_W-1:0] byte_t;

endpackage

@@ design/dual_key_feedback_xor_cipher_core.sv @@
// An accepted data item is registered in stage s1 with its key bytes, then in m_data_reg.
// Throughput: one item per cycle unless the output stalls on m_tready.
// The key stores are read once per data item at accept; key-write items produce no result.
// Reset (aresetn low, synchronous) empties the pipeline, clears the feedback and both key
// positions and sets both key lengths to 1; the key stores keep their contents.
module dual_key_feedback_xor_cipher_core import dkfx_pkg::*; #(
    parameter int KEY_DEPTH = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte, [13:8] key_index, [15:14] zero
    input  logic [TUSER_W-1:0]    s_tuser,   // [1:0] kind, [2] new_record
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [7:0] out_byte
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int PW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int LW = (PW + 1 > CFG_W) ? PW + 1 : CFG_W;
    localparam int IW = (PW > KEY_IDX_W) ? PW : KEY_IDX_W;

    byte_t key_a_mem [KEY_DEPTH];
    byte_t key_b_mem [KEY_DEPTH];

    logic [CFG_W-1:0] len_a_reg, len_b_reg;
    logic [PW-1:0]    pos_a_reg, pos_b_reg;
    logic [PW-1:0]    pos_a_next, pos_b_next;
    logic [PW-1:0]    cur_a, cur_b;
    byte_t            fb_reg, fb_next, fb_cur;
    logic             s1_valid_reg, s1_fresh_reg;
    byte_t            s1_byte_reg, ka_reg, kb_reg;
    logic             m_valid_reg;
    byte_t            m_data_reg;

    logic [KIND_W-1:0]    in_kind;
    logic                 in_fresh;
    byte_t                in_byte;
    logic [KEY_IDX_W-1:0] in_idx;
    logic [IW-1:0]        idx_ext;
    logic [PW-1:0]        wr_addr;
    logic                 idx_ok;
    logic                 fire_in, data_in, adv;
    logic [2*BYTE_W-1:0]  prod;

    function automatic logic [PW-1:0] step_pos(input logic [PW-1:0] pos,
                                               input logic [CFG_W-1:0] len);
        logic [LW-1:0] eff;
        logic [LW-1:0] nxt;
        eff = LW'(len);
        if (eff == '0) begin
            eff = LW'(1);
        end else if (eff > LW'(KEY_DEPTH)) begin
            eff = LW'(KEY_DEPTH);
        end
        nxt = LW'(pos) + LW'(1);
        if (nxt >= eff) begin
            nxt = '0;
        end
        return nxt[PW-1:0];
    endfunction

    assign in_kind  = s_tuser[KIND_W-1:0];
    assign in_fresh = s_tuser[KIND_W];
    assign in_byte  = s_tdata[BYTE_W-1:0];
    assign in_idx   = s_tdata[BYTE_W+KEY_IDX_W-1:BYTE_W];
    assign idx_ext  = IW'(in_idx);
    assign wr_addr  = idx_ext[PW-1:0];
    assign idx_ok   = LW'(in_idx) < LW'(KEY_DEPTH);

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || adv;
    assign fire_in  = s_tvalid && s_tready;
    assign data_in  = fire_in && (in_kind == KIND_DATA);

    assign cur_a      = in_fresh ? '0 : pos_a_reg;
    assign cur_b      = in_fresh ? '0 : pos_b_reg;
    assign pos_a_next = step_pos(cur_a, len_a_reg);
    assign pos_b_next = step_pos(cur_b, len_b_reg);

    assign fb_cur  = s1_fresh_reg ? '0 : fb_reg;
    assign prod    = ka_reg * kb_reg;
    assign fb_next = fb_cur + prod[BYTE_W-1:0];

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (fire_in && idx_ok && (in_kind == KIND_KEY_A)) begin
            key_a_mem[wr_addr] <= in_byte;
        end
        if (fire_in && idx_ok && (in_kind == KIND_KEY_B)) begin
            key_b_mem[wr_addr] <= in_byte;
        end
        if (data_in) begin
            ka_reg       <= key_a_mem[cur_a];
            kb_reg       <= key_b_mem[cur_b];
            s1_byte_reg  <= in_byte;
            s1_fresh_reg <= in_fresh;
        end
        if (adv && s1_valid_reg) begin
            m_data_reg <= s1_byte_reg ^ ka_reg ^ kb_reg ^ fb_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_a_reg    <= LEN_RESET;
            len_b_reg    <= LEN_RESET;
            pos_a_reg    <= '0;
            pos_b_reg    <= '0;
            fb_reg       <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_KEY_A_LEN: len_a_reg <= cfg_data;
                    REG_KEY_B_LEN: len_b_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (data_in) begin
                pos_a_reg <= pos_a_next;
                pos_b_reg <= pos_b_next;
            end
            if (adv && s1_valid_reg) begin
                fb_reg <= fb_next;
            end
            if (s_tready) begin
                s1_valid_reg <= data_in;
            end
            if (adv) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

endmodule

@@ design/dkfx_checker.sv @@
module dkfx_checker import dkfx_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [TUSER_W-1:0]    s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // an empty output always drains, so the input must be open
    a_no_deadlock: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // a fresh result comes only from an accepted data item, registered in s1 and then at the output
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |->
            $past(s_tvalid && s_tready && (s_tuser[KIND_W-1:0] == KIND_DATA), 2))
        else $error("result without a matching data item");

endmodule

bind dual_key_feedback_xor_cipher_core dkfx_checker u_dkfx_checker (.*);
